// File: design/ppds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppds_pkg: shared constants and types for the pinhole point depth splatter
// Register indexes, field widths and the divider request/response structs.
// ----------------------------------------------------------------------------
package ppds_pkg;

  localparam int unsigned PIXEL_CAPACITY_DEF = 524288;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

  // item commands
  localparam logic CMD_SPLAT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // numerator p*f + c*z fits in 42 bits signed; divisor 16*z in 28 bits
  localparam int unsigned NUM_W = 42;
  localparam int unsigned DEN_W = 28;
  localparam int unsigned DIM_MAX = 4096;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_u;   // magnitude of numerator
    logic             neg;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;    // truncated magnitude
    logic             neg;
  } div_rsp_t;

endpackage

// File: design/ppds_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppds_divider: radix-2 restoring divider
// One quotient bit per cycle; sign applied by the caller (truncation toward 0).
// ----------------------------------------------------------------------------
module ppds_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  ppds_pkg::div_req_t  req,
  output ppds_pkg::div_rsp_t  rsp
);

  localparam int unsigned N = ppds_pkg::NUM_W;
  localparam int unsigned D = ppds_pkg::DEN_W;
  localparam int unsigned CW = $clog2(N + 1);

  logic [N-1:0]  quot_r, quot_nxt;
  logic [D:0]    rem_r, rem_nxt;
  logic [D-1:0]  den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, neg_r;
  logic [D:0]    trial;
  logic [D:0]    shifted;

  // one shift-subtract step
  always_comb begin
    shifted  = {rem_r[D-1:0], quot_r[N-1]};
    trial    = shifted - {1'b0, den_r};
    rem_nxt  = trial[D] ? shifted : trial;
    quot_nxt = {quot_r[N-2:0], ~trial[D]};
    cnt_nxt  = cnt_r - CW'(1);
    busy_nxt = (cnt_r != CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(N);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      done_r <= ~busy_nxt;
      cnt_r  <= cnt_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.num_u;
      rem_r  <= '0;
      den_r  <= req.den;
      neg_r  <= req.neg;
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.neg  = neg_r;

endmodule

// File: design/pinhole_point_depth_splat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_depth_splat: pinhole projection into a z-buffered depth image
// Splat items project a point and keep the nearest per pixel; read items
// return one pixel and clear it.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid/in_stall carries one item (splat or read). Each item
//  yields exactly one result item on out_valid/out_stall.
//  A splat with a real point and z > 0 is worked as follows once it is taken:
//  u and v are each divided by one shared bit-serial divider (a start, then
//  one quotient bit per step of a 42-bit quotient, then done), then the pixel
//  index is formed, the memory is read, and the result is compared, written
//  back and loaded into the output register. A read item or a splat rejected
//  before the divide goes straight to the memory read. In either case the
//  next item can be taken once the result is loaded.
//  One item is in work at a time. A stalled result stays in the output
//  register; the next item is taken and worked up to its memory read, where
//  it waits until the output register is free.
//  Reset restores the intrinsics and starts a clearing pass over the
//  occupancy memory, one pixel per cycle, over all PIXEL_CAPACITY entries; no
//  item is taken during it. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module pinhole_point_depth_splat #(
  parameter int unsigned PIXEL_CAPACITY = ppds_pkg::PIXEL_CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ppds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic                                in_point_valid,
  input  logic signed [23:0]                  in_point_x,
  input  logic signed [23:0]                  in_point_y,
  input  logic signed [23:0]                  in_point_z,
  input  logic [31:0]                         in_point_color,
  input  logic [18:0]                         in_read_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_in_view,
  output logic [11:0]                         out_pixel_u,
  output logic [11:0]                         out_pixel_v,
  output logic                                out_replaced,
  output logic                                out_pixel_valid,
  output logic signed [23:0]                  out_out_x,
  output logic signed [23:0]                  out_out_y,
  output logic signed [23:0]                  out_out_z,
  output logic [31:0]                         out_out_color
);

  localparam int unsigned AW = $clog2(PIXEL_CAPACITY);
  localparam int unsigned NW = ppds_pkg::NUM_W;
  localparam int unsigned DW = ppds_pkg::DEN_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIVU  = 3'd2;
  localparam logic [2:0] ST_DIVV  = 3'd3;
  localparam logic [2:0] ST_INDEX = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_MOD   = 3'd6;

  // configuration registers
  logic [15:0] focal_x_r, focal_y_r;
  logic signed [15:0] center_x_r, center_y_r;
  logic [12:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 16'd8400;
      focal_y_r  <= 16'd8400;
      center_x_r <= 16'sd5112;
      center_y_r <= 16'sd3832;
      width_r    <= 13'd640;
      height_r   <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        ppds_pkg::REG_FOCAL_X:  focal_x_r  <= cfg_data;
        ppds_pkg::REG_FOCAL_Y:  focal_y_r  <= cfg_data;
        ppds_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        ppds_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        ppds_pkg::REG_WIDTH:    width_r    <= cfg_data[12:0];
        ppds_pkg::REG_HEIGHT:   height_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // saturated dimensions
  logic [12:0] w_sat, h_sat;
  assign w_sat = (width_r  > 13'(ppds_pkg::DIM_MAX)) ? 13'(ppds_pkg::DIM_MAX) : width_r;
  assign h_sat = (height_r > 13'(ppds_pkg::DIM_MAX)) ? 13'(ppds_pkg::DIM_MAX) : height_r;

  // memories: occupancy and point payload
  logic              occ_mem [PIXEL_CAPACITY];
  logic [103:0]      pt_mem  [PIXEL_CAPACITY];
  logic              occ_rd_r;
  logic [103:0]      pt_rd_r;
  logic              occ_we, pt_we, occ_wd;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [103:0]      pt_wd;

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[wr_addr] <= occ_wd;
    occ_rd_r <= occ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[wr_addr] <= pt_wd;
    pt_rd_r <= pt_mem[rd_addr];
  end

  // item registers
  logic [2:0]        state_r;
  logic [AW:0]       clr_cnt_r;
  logic              cmd_r;
  logic signed [23:0] x_r, y_r, z_r;
  logic [31:0]       color_r;
  logic [18:0]       ridx_r;
  logic signed [NW:0] u_r;
  logic signed [NW:0] v_r;
  logic [AW-1:0]     idx_r;
  logic              ok_r;
  logic              out_valid_r;

  ppds_pkg::div_req_t dreq;
  ppds_pkg::div_rsp_t drsp;

  ppds_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // numerator p*f + c*z and divisor 16*z for the selected axis
  logic signed [NW-1:0] num_s;
  logic signed [NW-1:0] pf, cz;
  logic                 sel_v;
  always_comb begin
    pf = sel_v ? NW'($signed({1'b0, focal_y_r})) * NW'(y_r)
               : NW'($signed({1'b0, focal_x_r})) * NW'(x_r);
    cz = sel_v ? NW'(center_y_r) * NW'(z_r) : NW'(center_x_r) * NW'(z_r);
    num_s = pf + cz;
  end

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  logic signed [NW:0] qs;
  assign qs = drsp.neg ? -$signed({1'b0, drsp.quot}) : $signed({1'b0, drsp.quot});

  always_comb begin
    dreq.start = 1'b0;
    // v is started in the cycle that u completes
    sel_v      = (state_r == ST_DIVU) && drsp.done;
    dreq.num_u = num_s[NW-1] ? NW'(-num_s) : num_s;
    dreq.neg   = num_s[NW-1];
    dreq.den   = {z_r, 4'b0000};
    // start u on the cycle after accept, v after u finishes
    if (state_r == ST_DIVU && !drsp.busy && !drsp.done && !ok_r) dreq.start = 1'b1;
    if (state_r == ST_DIVU && drsp.done) dreq.start = 1'b1;
  end

  // index and range checks
  logic in_range;
  logic [23:0] lin;
  assign in_range = !u_r[NW] && !v_r[NW] && (u_r < $signed({{(NW-12){1'b0}}, w_sat}))
                    && (v_r < $signed({{(NW-12){1'b0}}, h_sat}));
  assign lin = 24'(v_r[11:0]) * 24'(w_sat) + 24'(u_r[11:0]);

  logic        replace;
  assign replace = !occ_rd_r || ($signed(pt_rd_r[103:80]) > z_r);

  always_comb begin
    rd_addr = cmd_r ? AW'(ridx_r) : idx_r;
    wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r[AW-1:0] : rd_addr;
    occ_we  = (state_r == ST_CLEAR) || (state_r == ST_MOD && ok_r && (cmd_r || replace));
    occ_wd  = (state_r != ST_CLEAR) && !cmd_r;
    pt_we   = (state_r == ST_MOD) && ok_r && !cmd_r && replace;
    pt_wd   = {z_r, x_r, y_r, color_r};
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == (AW+1)'(PIXEL_CAPACITY - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          // reads check the index here; splats get ok_r after the divide
          ok_r <= accept && (in_command == ppds_pkg::CMD_READ)
                  && (32'(in_read_index) < PIXEL_CAPACITY);
          if (accept) begin
            if (in_command == ppds_pkg::CMD_READ) begin
              state_r <= ST_READ;
            end else if (in_point_valid && in_point_z > 0) begin
              state_r <= ST_DIVU;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        ST_DIVU: begin
          if (!drsp.busy && !drsp.done && !ok_r) ok_r <= 1'b1;
          if (drsp.done) begin
            u_r     <= qs;
            state_r <= ST_DIVV;
          end
        end
        ST_DIVV: begin
          if (drsp.done) begin
            v_r     <= qs;
            state_r <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          idx_r   <= lin[AW-1:0];
          ok_r    <= in_range && (32'(lin) < PIXEL_CAPACITY);
          state_r <= ST_READ;
        end
        // wait here until the output register is free
        ST_READ: if (!out_valid_r || !out_stall) state_r <= ST_MOD;
        ST_MOD: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      x_r     <= in_point_x;
      y_r     <= in_point_y;
      z_r     <= in_point_z;
      color_r <= in_point_color;
      ridx_r  <= in_read_index;
    end
  end

  // result register
  logic splat_ok, read_ok;
  assign splat_ok = ok_r && !cmd_r;
  assign read_ok  = ok_r && cmd_r && occ_rd_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_MOD) begin
      out_in_view     <= splat_ok;
      out_pixel_u     <= splat_ok ? u_r[11:0] : 12'd0;
      out_pixel_v     <= splat_ok ? v_r[11:0] : 12'd0;
      out_replaced    <= splat_ok && replace;
      out_pixel_valid <= read_ok;
      out_out_z       <= read_ok ? $signed(pt_rd_r[103:80]) : 24'sd0;
      out_out_x       <= read_ok ? $signed(pt_rd_r[79:56])  : 24'sd0;
      out_out_y       <= read_ok ? $signed(pt_rd_r[55:32])  : 24'sd0;
      out_out_color   <= read_ok ? pt_rd_r[31:0] : 32'd0;
    end
  end
  assign out_valid = out_valid_r;

  // assertions
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |=> out_valid) else $error("result not raised");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("item taken while busy");
  a_flag_unread: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_view) |-> !out_pixel_valid) else $error("mixed result");

endmodule

// File: verif/tb_pinhole_point_depth_splat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pinhole_point_depth_splat: self-checking bench for the depth splatter
// Drives splat and read items through several intrinsics and image sizes,
// predicts every result with a z-buffer model in the bench and compares each
// result item field by field. Both channels idle at random outside one stretch.
// ----------------------------------------------------------------------------
module tb_pinhole_point_depth_splat;

  localparam int unsigned CAPACITY = ppds_pkg::PIXEL_CAPACITY_DEF;
  localparam longint      CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic               command;
    logic               point_valid;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [31:0]        color;
    logic [18:0]        read_index;
  } item_t;

  typedef struct packed {
    logic               in_view;
    logic [11:0]        pixel_u;
    logic [11:0]        pixel_v;
    logic               replaced;
    logic               pixel_valid;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [31:0]        color;
  } pixel_result_t;

  // z-buffer predictor and store of expected result items
  class depth_image_scoreboard;
    logic [15:0]        focal_x, focal_y;
    logic signed [15:0] center_x, center_y;
    logic [12:0]        width, height;
    bit                 occupied[int];
    logic signed [23:0] depth_mem[int];
    logic signed [23:0] x_mem[int];
    logic signed [23:0] y_mem[int];
    logic [31:0]        color_mem[int];
    pixel_result_t      expected_pixels[$];
    int                 errors;

    function new();
      focal_x = 16'd8400; focal_y = 16'd8400;
      center_x = 16'sd5112; center_y = 16'sd3832;
      width = 13'd640; height = 13'd480;
      errors = 0;
    endfunction

    function void write_reg(logic [ppds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        ppds_pkg::REG_FOCAL_X:  focal_x = data;
        ppds_pkg::REG_FOCAL_Y:  focal_y = data;
        ppds_pkg::REG_CENTER_X: center_x = data;
        ppds_pkg::REG_CENTER_Y: center_y = data;
        ppds_pkg::REG_WIDTH:    width = data[12:0];
        ppds_pkg::REG_HEIGHT:   height = data[12:0];
        default: ;
      endcase
    endfunction

    // exact projection, truncated toward zero
    function longint project(longint p, longint f, longint c, longint z);
      longint num;
      num = p * f + c * z;
      return num / (16 * z);
    endfunction

    function void note_item(item_t it);
      pixel_result_t r;
      longint w, h, u, v, idx;
      r = '0;
      w = (width > 4096) ? 4096 : width;
      h = (height > 4096) ? 4096 : height;
      if (it.command == ppds_pkg::CMD_SPLAT) begin
        if (it.point_valid && it.z > 0) begin
          u = project(it.x, focal_x, center_x, it.z);
          v = project(it.y, focal_y, center_y, it.z);
          if (u >= 0 && v >= 0 && u < w && v < h) begin
            idx = v * w + u;
            if (idx < CAPACITY) begin
              r.in_view = 1'b1;
              r.pixel_u = u[11:0];
              r.pixel_v = v[11:0];
              if (!occupied.exists(idx) || depth_mem[idx] > it.z) begin
                occupied[idx] = 1'b1;
                depth_mem[idx] = it.z;
                x_mem[idx] = it.x;
                y_mem[idx] = it.y;
                color_mem[idx] = it.color;
                r.replaced = 1'b1;
              end
            end
          end
        end
      end else begin
        idx = it.read_index;
        if (occupied.exists(idx)) begin
          r.pixel_valid = 1'b1;
          r.x = x_mem[idx];
          r.y = y_mem[idx];
          r.z = depth_mem[idx];
          r.color = color_mem[idx];
          occupied.delete(idx);
        end
      end
      expected_pixels = {expected_pixels, r};
    endfunction

    function void check_result(pixel_result_t act);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (act.in_view !== e.in_view) begin
        $error("in_view exp %0d got %0d", e.in_view, act.in_view); errors++;
      end
      if (act.pixel_u !== e.pixel_u) begin
        $error("pixel_u exp %0d got %0d", e.pixel_u, act.pixel_u); errors++;
      end
      if (act.pixel_v !== e.pixel_v) begin
        $error("pixel_v exp %0d got %0d", e.pixel_v, act.pixel_v); errors++;
      end
      if (act.replaced !== e.replaced) begin
        $error("replaced exp %0d got %0d", e.replaced, act.replaced); errors++;
      end
      if (act.pixel_valid !== e.pixel_valid) begin
        $error("pixel_valid exp %0d got %0d", e.pixel_valid, act.pixel_valid); errors++;
      end
      if (act.x !== e.x) begin
        $error("out_x exp %0d got %0d", e.x, act.x); errors++;
      end
      if (act.y !== e.y) begin
        $error("out_y exp %0d got %0d", e.y, act.y); errors++;
      end
      if (act.z !== e.z) begin
        $error("out_z exp %0d got %0d", e.z, act.z); errors++;
      end
      if (act.color !== e.color) begin
        $error("out_color exp %h got %h", e.color, act.color); errors++;
      end
    endfunction
  endclass

  logic                            clk, rst_n;
  logic                            cfg_we;
  logic [ppds_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ppds_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid, in_stall;
  logic                            in_command, in_point_valid;
  logic signed [23:0]              in_point_x, in_point_y, in_point_z;
  logic [31:0]                     in_point_color;
  logic [18:0]                     in_read_index;
  logic                            out_valid, out_stall;
  logic                            out_in_view, out_replaced, out_pixel_valid;
  logic [11:0]                     out_pixel_u, out_pixel_v;
  logic signed [23:0]              out_out_x, out_out_y, out_out_z;
  logic [31:0]                     out_out_color;

  depth_image_scoreboard zbuf = new();
  bit                    quiet;       // no idling on either side
  longint                cycles;
  int                    hit_pixels[$];

  pinhole_point_depth_splat u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // accepted items on both channels
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      zbuf.check_result('{out_in_view, out_pixel_u, out_pixel_v, out_replaced,
                          out_pixel_valid, out_out_x, out_out_y, out_out_z,
                          out_out_color});
    if (rst_n && in_valid && !in_stall)
      zbuf.note_item('{in_command, in_point_valid, in_point_x, in_point_y,
                       in_point_z, in_point_color, in_read_index});
  end

  // receiver back-pressure
  always @(negedge clk)
    out_stall = !quiet && ($urandom_range(0, 99) < 12);

  task automatic send(item_t it);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {in_command, in_point_valid, in_point_x, in_point_y, in_point_z,
     in_point_color, in_read_index} = it;
    do @(posedge clk); while (in_stall);
    if (it.command == ppds_pkg::CMD_SPLAT && hit_pixels.size() > 64)
      void'(hit_pixels.pop_front());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (zbuf.expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = data;
    zbuf.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                            logic [15:0] cy, logic [15:0] w, logic [15:0] h);
    drain();
    write_reg(ppds_pkg::REG_FOCAL_X, fx);
    write_reg(ppds_pkg::REG_FOCAL_Y, fy);
    write_reg(ppds_pkg::REG_CENTER_X, cx);
    write_reg(ppds_pkg::REG_CENTER_Y, cy);
    write_reg(ppds_pkg::REG_WIDTH, w);
    write_reg(ppds_pkg::REG_HEIGHT, h);
  endtask

  function automatic item_t splat(logic pv, int x, int y, int z, logic [31:0] c);
    item_t it;
    it = '0;
    it.command = ppds_pkg::CMD_SPLAT; it.point_valid = pv;
    it.x = x; it.y = y; it.z = z; it.color = c;
    it.read_index = $urandom;
    return it;
  endfunction

  function automatic item_t read_px(int idx);
    item_t it;
    it = '0;
    it.command = ppds_pkg::CMD_READ;
    it.point_valid = $urandom; it.x = $urandom; it.y = $urandom;
    it.z = $urandom; it.color = $urandom;
    it.read_index = idx;
    return it;
  endfunction

  // point aimed at pixel (u, v) of the current camera
  function automatic item_t aimed(int u, int v, int z);
    longint f, px, py;
    f = (zbuf.focal_x == 0) ? 1 : zbuf.focal_x;
    px = ((longint'(u) * 16 + 8 - zbuf.center_x) * z) / f;
    f = (zbuf.focal_y == 0) ? 1 : zbuf.focal_y;
    py = ((longint'(v) * 16 + 8 - zbuf.center_y) * z) / f;
    if (px > 8388607) px = 8388607;
    if (px < -8388608) px = -8388608;
    if (py > 8388607) py = 8388607;
    if (py < -8388608) py = -8388608;
    return splat(1'b1, int'(px), int'(py), z, $urandom);
  endfunction

  // mostly in-view splats and reads of recently hit pixels, some noise
  task automatic random_phase(int n, int pool);
    int w, h, u, v, k;
    item_t it;
    w = (zbuf.width > 4096) ? 4096 : zbuf.width;
    h = (zbuf.height > 4096) ? 4096 : zbuf.height;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50 && w > 0 && h > 0) begin
        u = $urandom_range(0, (pool < w ? pool : w) - 1);
        v = $urandom_range(0, (pool < h ? pool : h) - 1);
        it = aimed(u, v, $urandom_range(1, 1 << 19));
        hit_pixels = {hit_pixels, v * w + u};
      end else if (k < 80) begin
        if (hit_pixels.size() > 0 && $urandom_range(0, 3) != 0)
          it = read_px(hit_pixels[$urandom_range(0, hit_pixels.size() - 1)]);
        else
          it = read_px($urandom_range(0, 524287));
      end else begin
        it = splat($urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send(it);
    end
  endtask

  initial begin
    rst_n = 1'b0; quiet = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_command = 1'b0; in_point_valid = 1'b0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_point_color = '0; in_read_index = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset camera, center pixel (319, 239) is index 153279
    send(splat(1'b1, 0, 0, 32'h10000, 32'hFFFFFFFF));
    send(splat(1'b1, 0, 0, 32'h10000, 32'h11111111));     // equal depth, kept
    send(splat(1'b1, 0, 0, 32'h20000, 32'h22222222));     // farther, kept
    send(splat(1'b1, 0, 0, 32'h08000, 32'h00000000));     // nearer, replaces
    send(read_px(153279));
    send(read_px(153279));                                // now empty
    send(splat(1'b0, 0, 0, 32'h10000, 32'h12345678));     // invalid point
    send(splat(1'b1, 0, 0, 0, 32'h1));                    // z zero
    send(splat(1'b1, 0, 0, -8388608, 32'h2));             // z negative
    send(splat(1'b1, 8388607, 8388607, 1, 32'h3));        // far outside
    send(splat(1'b1, -8388608, -8388608, 8388607, 32'h4));
    send(splat(1'b1, 8388607, -8388608, 8388607, 32'h5));
    send(splat(1'b1, -8388608, 8388607, 8388607, 32'h6));
    send(splat(1'b1, -2500, -2500, 8388607, 32'hA5A5A5A5));
    send(read_px(0));
    send(read_px(524287));
    send(read_px(307199));

    // capacity check and saturated sizes: pixel (100, 200) at 4096 wide
    set_camera(16'd16, 16'd16, 16'd0, 16'd0, 16'd8191, 16'd4097);
    send(splat(1'b1, 32'd100 << 16, 32'd200 << 16, 32'h10000, 32'h7));
    send(splat(1'b1, 32'd100 << 16, 32'd100 << 16, 32'h10000, 32'h8));
    send(read_px(100 * 4096 + 100));
    send(splat(1'b1, -32'sd65535, 0, 32'h10000, 32'h9));  // u in (-1,0) -> 0
    send(read_px(0));

    // random phases across camera settings; one stretch without idling
    set_camera(16'd8400, 16'd8400, 16'd5112, 16'd3832, 16'd640, 16'd480);
    random_phase(150, 640);
    set_camera(16'd256, 16'd256, 16'd64, 16'd64, 16'd8, 16'd8);
    quiet = 1'b1;
    random_phase(200, 8);
    quiet = 1'b0;
    set_camera(16'd65535, 16'd1, 16'sh7FFF, -16'sd32768, 16'd4096, 16'd4096);
    random_phase(150, 4096);
    set_camera(16'd0, 16'd0, 16'd160, 16'd80, 16'd32, 16'd16);
    random_phase(100, 32);
    set_camera(16'd1, 16'd65535, -16'sd32768, 16'sh7FFF, 16'd0, 16'd0);
    random_phase(80, 16);
    set_camera(16'd1000, 16'd1200, 16'd300, 16'd200, 16'd1, 16'd1);
    random_phase(100, 1);
    set_camera(16'd4000, 16'd4000, 16'd1000, 16'd800, 16'd64, 16'd40);
    random_phase(270, 20);

    drain();
    repeat (200) @(posedge clk);
    if (zbuf.errors == 0 && zbuf.expected_pixels.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
